/* hw/rtl/iged_pkg.sv */
// shared constants, codes and types of the gradient edge detector
package iged_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 11;
  localparam int IDX_W      = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // register indexes on the config port
  localparam logic [IDX_W-1:0] REG_OP_MODE        = 3'd0;
  localparam logic [IDX_W-1:0] REG_BYPASS_ON      = 3'd1;
  localparam logic [IDX_W-1:0] REG_BORDER_RULE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_EDGE_THRESHOLD = 3'd3;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd4;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd5;

  // operating modes
  localparam logic [1:0] OP_HGRAD = 2'd0;
  localparam logic [1:0] OP_VGRAD = 2'd1;
  localparam logic [1:0] OP_L1    = 2'd2;
  localparam logic [1:0] OP_EDGE  = 2'd3;

  // border rule codes
  localparam logic BORDER_ZERO   = 1'b0;
  localparam logic BORDER_CENTRE = 1'b1;

  // result slot indexes inside one queue entry
  localparam logic [1:0] SLOT_ABOVE = 2'd0;
  localparam logic [1:0] SLOT_LEFT  = 2'd1;
  localparam logic [1:0] SLOT_END   = 2'd2;

  typedef struct packed {
    logic [1:0]        op_mode;
    logic              bypass_on;
    logic              border_rule;
    logic [PIX_W-1:0]  edge_threshold;
    logic [SIZE_W-1:0] image_width;
    logic [SIZE_W-1:0] image_height;
  } cfg_t;

  // one pending result: neighbours of the centre, or the raw pixel in bypass
  typedef struct packed {
    logic             byp;
    logic             last;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] down;
  } slot_t;

  typedef struct packed {
    logic [1:0]  last_idx;
    slot_t [2:0] slots;
  } entry_t;

endpackage

/* hw/rtl/iged_front.sv */
// front end: raster counters, line stores, neighbour window and result slots
module iged_front (
  input  logic                  clk,
  input  logic                  rst,
  input  iged_pkg::cfg_t        cfg,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] pixel_in
  input  logic                  q_full,
  output logic                  push,
  output iged_pkg::entry_t      push_data
);

  localparam int CW = iged_pkg::COL_W;
  localparam int RW = iged_pkg::ROW_W;
  localparam int PW = iged_pkg::PIX_W;

  // two line stores; sel picks which one takes the incoming row
  logic [PW-1:0] mem0 [iged_pkg::MAX_WIDTH];
  logic [PW-1:0] mem1 [iged_pkg::MAX_WIDTH];
  logic [PW-1:0] rd0, rd1;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          sel;

  // window over the stored row and history of the incoming row
  logic [PW-1:0] wl, wc, p1, p2, first_wr;

  logic          accept;
  logic [PW-1:0] p;
  logic [CW:0]   w_eff;
  logic [RW:0]   h_eff;
  logic          outside;
  logic [CW-1:0] c, c_next, w_m1;
  logic [RW-1:0] r, r_next, h_m1;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          wrap, sel_next;
  logic [CW-1:0] a0, a1;
  logic [PW-1:0] rd_up, rd_cur;
  logic          last_row, last_col;

  function automatic logic [PW-1:0] nbv(input logic rule, input logic [PW-1:0] centre);
    return (rule == iged_pkg::BORDER_CENTRE) ? centre : '0;
  endfunction

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign p        = s_tdata;

  // clamp the image size
  always_comb begin
    if (cfg.image_width < iged_pkg::SIZE_W'(2)) begin
      w_eff = (CW+1)'(2);
    end else if (int'(cfg.image_width) > iged_pkg::MAX_WIDTH) begin
      w_eff = (CW+1)'(iged_pkg::MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(cfg.image_width);
    end
    if (cfg.image_height < iged_pkg::SIZE_W'(2)) begin
      h_eff = (RW+1)'(2);
    end else if (int'(cfg.image_height) > iged_pkg::MAX_HEIGHT) begin
      h_eff = (RW+1)'(iged_pkg::MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(cfg.image_height);
    end
  end

  // position of this word and of the next one
  always_comb begin
    outside  = ({1'b0, row} >= h_eff) || ({1'b0, col} >= w_eff);
    r        = outside ? '0 : row;
    c        = outside ? '0 : col;
    w_m1     = CW'(w_eff - 1'b1);
    h_m1     = RW'(h_eff - 1'b1);
    last_row = (r == h_m1);
    last_col = (c == w_m1);
    col_inc  = {1'b0, c} + 1'b1;
    row_inc  = {1'b0, r} + 1'b1;
    wrap     = (col_inc >= w_eff);
    c_next   = wrap ? '0 : col_inc[CW-1:0];
    if (!wrap) begin
      r_next = r;
    end else if (row_inc >= h_eff) begin
      r_next = '0;
    end else begin
      r_next = row_inc[RW-1:0];
    end
    sel_next = wrap ? !sel : sel;
    // next row's upper store reads at the next column, the stored row one ahead
    a0 = (sel_next == 1'b0) ? c_next : c_next + CW'(1);
    a1 = (sel_next == 1'b1) ? c_next : c_next + CW'(1);
    rd_up  = sel ? rd1 : rd0;
    rd_cur = sel ? rd0 : rd1;
  end

  // line stores: write the incoming pixel, prefetch for the next word
  always_ff @(posedge clk) begin
    if (accept) begin
      if (sel == 1'b0) begin
        mem0[c] <= p;
      end
      if (sel == 1'b0 && c == a0) begin
        rd0 <= p;
      end else begin
        rd0 <= mem0[a0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (sel == 1'b1) begin
        mem1[c] <= p;
      end
      if (sel == 1'b1 && c == a1) begin
        rd1 <= p;
      end else begin
        rd1 <= mem1[a1];
      end
    end
  end

  // counters and store roles
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      sel <= 1'b0;
    end else if (accept) begin
      col <= c_next;
      row <= r_next;
      sel <= sel_next;
    end
  end

  // neighbour window
  always_ff @(posedge clk) begin
    if (accept) begin
      p1 <= p;
      p2 <= p1;
      if (c == '0) begin
        first_wr <= p;
      end
      if (wrap) begin
        wc <= first_wr;
      end else begin
        wl <= wc;
        wc <= rd_cur;
      end
    end
  end

  // result slots for this word
  always_comb begin
    push_data = '0;
    if (cfg.bypass_on) begin
      push_data.slots[iged_pkg::SLOT_ABOVE].byp  = 1'b1;
      push_data.slots[iged_pkg::SLOT_ABOVE].last = last_row && last_col;
      push_data.slots[iged_pkg::SLOT_ABOVE].left = p;
      push_data.last_idx = iged_pkg::SLOT_ABOVE;
    end else begin
      // centre one row up
      push_data.slots[iged_pkg::SLOT_ABOVE].left =
        (c == '0) ? nbv(cfg.border_rule, wc) : wl;
      push_data.slots[iged_pkg::SLOT_ABOVE].right =
        last_col ? nbv(cfg.border_rule, wc) : rd_cur;
      push_data.slots[iged_pkg::SLOT_ABOVE].up =
        (r == RW'(1)) ? nbv(cfg.border_rule, wc) : rd_up;
      push_data.slots[iged_pkg::SLOT_ABOVE].down = p;
      // last row, centre one column left
      push_data.slots[iged_pkg::SLOT_LEFT].left =
        (c == CW'(1)) ? nbv(cfg.border_rule, p1) : p2;
      push_data.slots[iged_pkg::SLOT_LEFT].right = p;
      push_data.slots[iged_pkg::SLOT_LEFT].up    = wl;
      push_data.slots[iged_pkg::SLOT_LEFT].down  = nbv(cfg.border_rule, p1);
      // last pixel of the image
      push_data.slots[iged_pkg::SLOT_END].left  = p1;
      push_data.slots[iged_pkg::SLOT_END].right = nbv(cfg.border_rule, p);
      push_data.slots[iged_pkg::SLOT_END].up    = wc;
      push_data.slots[iged_pkg::SLOT_END].down  = nbv(cfg.border_rule, p);
      push_data.slots[iged_pkg::SLOT_END].last  = 1'b1;
      if (last_row && last_col) begin
        push_data.last_idx = iged_pkg::SLOT_END;
      end else if (last_row && c != '0) begin
        push_data.last_idx = iged_pkg::SLOT_LEFT;
      end else begin
        push_data.last_idx = iged_pkg::SLOT_ABOVE;
      end
    end
    push = accept && (cfg.bypass_on || r != '0);
  end

endmodule

/* hw/rtl/iged_fifo.sv */
// short queue of result slot groups between front and back
module iged_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  iged_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output iged_pkg::entry_t head,
  output logic             head_valid
);

  localparam int PTRW = iged_pkg::FIFO_PTR_W;

  iged_pkg::entry_t store [iged_pkg::FIFO_DEPTH];
  logic [PTRW-1:0]  wr_ptr, rd_ptr;
  logic [PTRW:0]    count;

  assign full       = (count == (PTRW+1)'(iged_pkg::FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head       = store[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/iged_back.sv */
// back end: gradient arithmetic, mode select and output register
module iged_back (
  input  logic             clk,
  input  logic             rst,
  input  iged_pkg::cfg_t   cfg,
  input  iged_pkg::entry_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [7:0] pixel_out
  output logic             m_tlast    // frame_end
);

  localparam int PW = iged_pkg::PIX_W;

  logic [1:0]       idx;
  iged_pkg::slot_t  cur;
  logic             load;
  logic [PW-1:0]    h, v, hm, vm, m, val;

  // central difference halved, truncated toward zero
  function automatic logic [PW-1:0] half_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic signed [PW:0] d;
    logic signed [PW:0] q;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    q = (d + (d[PW] ? (PW+1)'(1) : (PW+1)'(0))) >>> 1;
    return q[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] mag(input logic [PW-1:0] g);
    return g[PW-1] ? PW'(-g) : g;
  endfunction

  assign cur  = head.slots[idx];
  assign load = head_valid && (!m_tvalid || m_tready);
  assign pop  = load && (idx == head.last_idx);

  // result value of the slot at hand
  always_comb begin
    h  = half_diff(cur.right, cur.left);
    v  = half_diff(cur.down, cur.up);
    hm = mag(h);
    vm = mag(v);
    m  = hm + vm;
    unique case (cfg.op_mode)
      iged_pkg::OP_HGRAD: val = h;
      iged_pkg::OP_VGRAD: val = v;
      iged_pkg::OP_L1:    val = m;
      iged_pkg::OP_EDGE:  val = (m < cfg.edge_threshold) ? '0 : '1;
      default:            val = '0;
    endcase
    if (cur.byp) begin
      val = cur.left;
    end
  end

  // slot walk and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= pop ? '0 : idx + 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= val;
      m_tlast <= cur.last;
    end
  end

endmodule

/* hw/rtl/image_gradient_edge_detector.sv */
// top level of the streaming gradient and edge detector
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  s_tdata[7:0] pixel_in
//  m_*       out  m_tvalid / m_tready  m_tdata[7:0] pixel_out, m_tlast frame_end
//  cfg_*     in   cfg_we               cfg_index[2:0], cfg_data[10:0]
//
// one pixel a cycle while the queue has room; in the last row, unless bypassed,
// a pixel makes one to three words and the output register takes one word a
// cycle while the receiver is ready, so the queue can fill there.
// a result passes the queue store and then the output register.
// a four-entry queue between front and back absorbs output stalls; the input
// stalls once it is full. reset clears counters, queue, output valid and
// configuration; the line stores and data registers are not cleared.
module image_gradient_edge_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] pixel_in
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] pixel_out
  output logic                          m_tlast,   // frame_end
  input  logic                          cfg_we,
  input  logic [iged_pkg::IDX_W-1:0]    cfg_index,
  input  logic [iged_pkg::SIZE_W-1:0]   cfg_data
);

  iged_pkg::cfg_t   cfg;
  iged_pkg::entry_t push_data, head;
  logic             push, q_full, pop, head_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.op_mode        <= iged_pkg::OP_HGRAD;
      cfg.bypass_on      <= 1'b0;
      cfg.border_rule    <= iged_pkg::BORDER_ZERO;
      cfg.edge_threshold <= '0;
      cfg.image_width    <= iged_pkg::SIZE_W'(iged_pkg::MAX_WIDTH);
      cfg.image_height   <= iged_pkg::SIZE_W'(iged_pkg::MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        iged_pkg::REG_OP_MODE:        cfg.op_mode        <= cfg_data[1:0];
        iged_pkg::REG_BYPASS_ON:      cfg.bypass_on      <= cfg_data[0];
        iged_pkg::REG_BORDER_RULE:    cfg.border_rule    <= cfg_data[0];
        iged_pkg::REG_EDGE_THRESHOLD: cfg.edge_threshold <= cfg_data[7:0];
        iged_pkg::REG_IMAGE_WIDTH:    cfg.image_width    <= cfg_data;
        iged_pkg::REG_IMAGE_HEIGHT:   cfg.image_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  iged_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  iged_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  iged_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

/* hw/rtl/iged_checker.sv */
// port-level checks of the gradient edge detector, bound to the top level
module iged_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // input backpressure only comes from pending output words
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no output word pending");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  // input is ready right after reset
  a_ready_after_reset: assert property (@(posedge clk) $fell(rst) |-> s_tready)
    else $error("input not ready after reset");

endmodule

bind image_gradient_edge_detector iged_checker u_iged_checker (.*);

/* tb/testbench.sv */
// self-checking stream testbench for the gradient and edge detector
module testbench;

  typedef enum logic [1:0] {PAT_FLAT, PAT_CHECKER, PAT_RANDOM, PAT_EXTREME} pattern_t;
  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY_READY, RX_MOSTLY_STALLED, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    logic [iged_pkg::PIX_W-1:0] value;
    logic                       frame_end;
  } grad_word_t;

  // one directed image: settings, size, content and an optional constant result
  typedef struct packed {
    logic [1:0]                  op;
    logic                        byp;
    logic                        brd;
    logic [iged_pkg::PIX_W-1:0]  thr;
    logic [iged_pkg::SIZE_W-1:0] w;
    logic [iged_pkg::SIZE_W-1:0] h;
    pattern_t                    pat;
    logic [iged_pkg::PIX_W-1:0]  level;
    logic                        has_const;
    logic [iged_pkg::PIX_W-1:0]  const_val;
  } directed_image_t;

  localparam int N_DIRECTED = 7;
  localparam int HOLD_CYCLES = 120;
  localparam int ERR_PRINT_CAP = 40;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [7:0]                  s_tdata = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [7:0]                  m_tdata;
  logic                        m_tlast;
  logic                        cfg_we = 1'b0;
  logic [iged_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [iged_pkg::SIZE_W-1:0] cfg_data = '0;

  image_gradient_edge_detector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [7:0] pixel_in
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [7:0] pixel_out
    .m_tlast   (m_tlast),   // frame_end
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  // shadow copy of the registers
  logic [1:0]                  cur_op = iged_pkg::OP_HGRAD;
  logic                        cur_bypass = 1'b0;
  logic                        cur_border = iged_pkg::BORDER_ZERO;
  logic [iged_pkg::PIX_W-1:0]  cur_thresh = '0;
  logic [iged_pkg::SIZE_W-1:0] cur_width = 11'd1024;
  logic [iged_pkg::SIZE_W-1:0] cur_height = 11'd1024;

  // shadow line stores and raster position
  logic [7:0] line_mem [2][iged_pkg::MAX_WIDTH];
  bit         upper_bank = 1'b0;
  int         row_pos = 0;
  int         col_pos = 0;

  grad_word_t  gradient_queue [$];
  logic [7:0]  pixel_feed [$];
  int          pixels_outstanding = 0;
  int          pixels_taken = 0;
  int          fail_count = 0;
  bit          force_en = 1'b0;
  logic [7:0]  force_val = '0;

  function automatic int clamp_dim(int v, int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int neighbour(bit outside, int val, int centre);
    if (outside) return (cur_border == iged_pkg::BORDER_CENTRE) ? centre : 0;
    return val;
  endfunction

  // central differences, halved toward zero, then the selected mode
  function automatic logic [7:0] gradient_byte(int l, int r, int u, int d);
    int gh, gv, mg;
    gh = (r - l) / 2;
    gv = (d - u) / 2;
    mg = (gh < 0 ? -gh : gh) + (gv < 0 ? -gv : gv);
    case (cur_op)
      iged_pkg::OP_HGRAD: return gh[7:0];
      iged_pkg::OP_VGRAD: return gv[7:0];
      iged_pkg::OP_L1:    return mg[7:0];
      default:            return (mg < int'(cur_thresh)) ? 8'd0 : 8'd255;
    endcase
  endfunction

  task automatic push_gradient(logic [7:0] val, logic last);
    grad_word_t g;
    g.value = force_en ? force_val : val;
    g.frame_end = last;
    gradient_queue.push_back(g);
  endtask

  // advance the shadow model by one pixel and queue the words it releases
  task automatic predict_pixel(logic [7:0] p);
    int w, hgt, r, c, ce, l, rt, up;
    bit cb;
    w = clamp_dim(cur_width, iged_pkg::MAX_WIDTH);
    hgt = clamp_dim(cur_height, iged_pkg::MAX_HEIGHT);
    if (row_pos >= hgt || col_pos >= w) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    cb = ~upper_bank;
    if (cur_bypass) begin
      push_gradient(p, (r == hgt - 1 && c == w - 1));
    end else if (r >= 1) begin
      ce = line_mem[cb][c];
      l  = neighbour(c == 0, c > 0 ? int'(line_mem[cb][c-1]) : 0, ce);
      rt = neighbour(c == w - 1, c + 1 < w ? int'(line_mem[cb][c+1]) : 0, ce);
      up = neighbour(r == 1, r >= 2 ? int'(line_mem[upper_bank][c]) : 0, ce);
      push_gradient(gradient_byte(l, rt, up, int'(p)), 1'b0);
    end
    line_mem[upper_bank][c] = p;
    // last row flushes its own results alongside the row above
    if (!cur_bypass && r == hgt - 1) begin
      if (c >= 1) begin
        ce = line_mem[upper_bank][c-1];
        l  = neighbour(c == 1, c >= 2 ? int'(line_mem[upper_bank][c-2]) : 0, ce);
        push_gradient(gradient_byte(l, int'(p), int'(line_mem[cb][c-1]),
                                    neighbour(1'b1, 0, ce)), 1'b0);
      end
      if (c == w - 1) begin
        push_gradient(gradient_byte(int'(line_mem[upper_bank][c-1]),
                                    neighbour(1'b1, 0, int'(p)),
                                    int'(line_mem[cb][c]),
                                    neighbour(1'b1, 0, int'(p))), 1'b1);
      end
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      upper_bank = ~upper_bank;
      row_pos = r + 1;
      if (row_pos >= hgt) row_pos = 0;
    end
  endtask

  task automatic check_word(logic [7:0] got_pix, logic got_last);
    grad_word_t e;
    if (gradient_queue.size() == 0) begin
      if (fail_count < ERR_PRINT_CAP)
        $error("unexpected word: pixel_out %0d frame_end %0d", got_pix, got_last);
      fail_count++;
    end else begin
      e = gradient_queue.pop_front();
      if (got_pix !== e.value) begin
        if (fail_count < ERR_PRINT_CAP)
          $error("pixel_out mismatch: expected %0d, actual %0d", e.value, got_pix);
        fail_count++;
      end
      if (got_last !== e.frame_end) begin
        if (fail_count < ERR_PRINT_CAP)
          $error("frame_end mismatch: expected %0d, actual %0d", e.frame_end, got_last);
        fail_count++;
      end
    end
  endtask

  // sender in bursts, input prediction and output checking
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_word(m_tdata, m_tlast);
      if (s_tvalid && s_tready) begin
        predict_pixel(s_tdata);
        pixels_taken++;
        pixels_outstanding--;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pixel_feed.size() > 0) begin
          s_tdata <= pixel_feed.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off now and then
  rx_mode_t   rx_mode = RX_OPEN;
  int         mode_left = 0;
  int         hold_left = 0;
  int         next_hold = 60;
  logic [2:0] rx_phase = '0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_phase <= rx_phase + 3'd1;
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 200);
      end else begin
        mode_left--;
      end
      if (hold_left == 0 && pixels_taken >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = next_hold + 90;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:           m_tready <= 1'b1;
          RX_MOSTLY_READY:   m_tready <= ($urandom_range(0, 3) != 0);
          RX_MOSTLY_STALLED: m_tready <= ($urandom_range(0, 3) == 0);
          default:           m_tready <= (rx_phase != 3'd5);
        endcase
      end
    end
  end

  task automatic write_reg(logic [iged_pkg::IDX_W-1:0] idx,
                           logic [iged_pkg::SIZE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      iged_pkg::REG_OP_MODE:        cur_op = val[1:0];
      iged_pkg::REG_BYPASS_ON:      cur_bypass = val[0];
      iged_pkg::REG_BORDER_RULE:    cur_border = val[0];
      iged_pkg::REG_EDGE_THRESHOLD: cur_thresh = val[7:0];
      iged_pkg::REG_IMAGE_WIDTH:    cur_width = val;
      iged_pkg::REG_IMAGE_HEIGHT:   cur_height = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all pixels taken and all words seen, then let the pipeline settle
  task automatic wait_idle();
    while (pixels_outstanding != 0 || gradient_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic setup_image(logic [1:0] op, logic byp, logic brd, logic [7:0] thr,
                             logic [iged_pkg::SIZE_W-1:0] w,
                             logic [iged_pkg::SIZE_W-1:0] h);
    wait_idle();
    write_reg(iged_pkg::REG_OP_MODE, iged_pkg::SIZE_W'(op));
    write_reg(iged_pkg::REG_BYPASS_ON, iged_pkg::SIZE_W'(byp));
    write_reg(iged_pkg::REG_BORDER_RULE, iged_pkg::SIZE_W'(brd));
    write_reg(iged_pkg::REG_EDGE_THRESHOLD, iged_pkg::SIZE_W'(thr));
    write_reg(iged_pkg::REG_IMAGE_WIDTH, w);
    write_reg(iged_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  function automatic logic [7:0] make_pixel(pattern_t pat, logic [7:0] level, int r, int c);
    case (pat)
      PAT_FLAT:    return level;
      PAT_CHECKER: return ((r + c) % 2 == 1) ? ~level : level;
      PAT_RANDOM:  return 8'($urandom_range(0, 255));
      default:     return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // queue one whole image so the block always ends at a frame boundary
  task automatic queue_image(pattern_t pat, logic [7:0] level, output int n_pix);
    int w, hgt;
    w = clamp_dim(cur_width, iged_pkg::MAX_WIDTH);
    hgt = clamp_dim(cur_height, iged_pkg::MAX_HEIGHT);
    n_pix = w * hgt;
    pixels_outstanding += n_pix;
    for (int r = 0; r < hgt; r++)
      for (int c = 0; c < w; c++)
        pixel_feed.push_back(make_pixel(pat, level, r, c));
  endtask

  function automatic logic [iged_pkg::SIZE_W-1:0] rand_size(int hi);
    case ($urandom_range(0, 19))
      0:       return 11'd0;
      1:       return 11'd1;
      default: return iged_pkg::SIZE_W'($urandom_range(2, hi));
    endcase
  endfunction

  directed_image_t dir_tab [N_DIRECTED];

  // main sequence
  initial begin
    int n_pix, pixels_sent, drain;
    logic [7:0] thr;
    pixels_sent = 0;

    // constant results where they are obvious, model otherwise
    dir_tab[0] = '{iged_pkg::OP_HGRAD, 1'b1, iged_pkg::BORDER_ZERO, 8'd0, 11'd2, 11'd2,
                   PAT_FLAT, 8'd255, 1'b1, 8'd255};
    dir_tab[1] = '{iged_pkg::OP_EDGE, 1'b0, iged_pkg::BORDER_ZERO, 8'd0, 11'd2, 11'd2,
                   PAT_FLAT, 8'd0, 1'b1, 8'd255};
    dir_tab[2] = '{iged_pkg::OP_HGRAD, 1'b0, iged_pkg::BORDER_CENTRE, 8'd0, 11'd2, 11'd2,
                   PAT_FLAT, 8'd200, 1'b1, 8'd0};
    dir_tab[3] = '{iged_pkg::OP_HGRAD, 1'b0, iged_pkg::BORDER_ZERO, 8'd0, 11'd2, 11'd2,
                   PAT_CHECKER, 8'd255, 1'b0, 8'd0};
    dir_tab[4] = '{iged_pkg::OP_VGRAD, 1'b0, iged_pkg::BORDER_ZERO, 8'd0, 11'd2, 11'd2,
                   PAT_CHECKER, 8'd0, 1'b0, 8'd0};
    dir_tab[5] = '{iged_pkg::OP_L1, 1'b0, iged_pkg::BORDER_CENTRE, 8'd0, 11'd2, 11'd2,
                   PAT_CHECKER, 8'd255, 1'b0, 8'd0};
    dir_tab[6] = '{iged_pkg::OP_EDGE, 1'b0, iged_pkg::BORDER_ZERO, 8'd255, 11'd2, 11'd2,
                   PAT_CHECKER, 8'd0, 1'b0, 8'd0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed images
    for (int i = 0; i < N_DIRECTED; i++) begin
      setup_image(dir_tab[i].op, dir_tab[i].byp, dir_tab[i].brd, dir_tab[i].thr,
                  dir_tab[i].w, dir_tab[i].h);
      force_en = dir_tab[i].has_const;
      force_val = dir_tab[i].const_val;
      queue_image(dir_tab[i].pat, dir_tab[i].level, n_pix);
      wait_idle();
      force_en = 1'b0;
    end

    // random small images with random settings
    while (pixels_sent < 270) begin
      case ($urandom_range(0, 7))
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        default: thr = 8'($urandom_range(0, 255));
      endcase
      setup_image(2'($urandom_range(0, 3)), ($urandom_range(0, 5) == 0),
                  1'($urandom_range(0, 1)), thr, rand_size(9), rand_size(5));
      queue_image(pattern_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), n_pix);
      pixels_sent += n_pix;
    end

    // drain
    while (pixels_outstanding != 0) @(posedge clk);
    drain = 0;
    while (gradient_queue.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (gradient_queue.size() != 0) begin
      $error("%0d expected words never arrived", gradient_queue.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
